// ----- src/urs_pkg.sv -----
`default_nettype none
package urs_pkg;

	localparam logic [1:0] FN_TICK = 2'd0;
	localparam logic [1:0] FN_EDGE = 2'd1;
	localparam logic [1:0] FN_PING = 2'd2;

	localparam logic [1:0] CFG_TEMP     = 2'd0;
	localparam logic [1:0] CFG_PWR_CTRL = 2'd1;
	localparam logic [1:0] CFG_PWR_UP   = 2'd2;

	localparam int SUM_W  = 24;
	localparam int LEN_W  = 18;
	localparam int SPD_W  = 19;
	localparam int PROD_W = SUM_W + SPD_W;
	localparam int QBITS  = 17;
	localparam int HI_W   = PROD_W - QBITS;

	localparam logic [7:0]       GUARD_MS   = 8'd200;
	localparam logic [7:0]       TIMEOUT_MS = 8'd200;
	localparam logic [LEN_W-1:0] LEN_MAX    = {LEN_W{1'b1}};
	localparam logic [SUM_W-1:0] SUM_MAX    = {SUM_W{1'b1}};
	localparam logic [15:0]      RANGE_RST  = 16'd999;
	localparam logic [15:0]      RANGE_MAX  = 16'hFFFF;

	localparam int SPEED_BASE  = 331300;
	localparam int SPEED_SLOPE = 606;
	localparam int DIV_SCALE   = 2000000;

	typedef enum logic [1:0] {
		ST_NONE    = 2'd0,
		ST_READING = 2'd1,
		ST_TIMEOUT = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [7:0] temperature_c;
		logic              power_control_present;
		logic [15:0]       power_up_ms;
	} cfg_t;

	typedef struct packed {
		logic    trigger_pulse;
		logic    power_enable;
		status_t reading_status;
		logic    need_avg;
	} step_res_t;

	typedef enum logic {
		T_IDLE,
		T_AVG
	} top_state_t;

	typedef enum logic [2:0] {
		A_IDLE,
		A_MUL,
		A_PRE,
		A_DIV,
		A_DONE
	} avg_state_t;

endpackage
`default_nettype wire

// ----- src/ultrasonic_range_sequencer.sv -----
// A tick, edge or ping request that needs no averaging has its result registered in the cycle after acceptance.
// A tick that completes a reading runs one setup, one multiply, one overflow check
// and 17 quotient steps of the shared subtractor (skipped on overflow), then the result.
// Throughput: one request per cycle while no reading completes; item_ready is low
// during averaging and while an unaccepted result blocks the output register.
// Reset clears all sequencing state, sets the last range to 999 and registers to defaults.
`default_nettype none
module ultrasonic_range_sequencer #(
	parameter int MAX_PINGS = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_ready,
	input  wire logic [1:0]         func,
	input  wire logic               echo_level,
	input  wire logic [31:0]        edge_time_us,
	input  wire logic [6:0]         ping_count,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output logic                    trigger_pulse,
	output logic                    power_enable,
	output logic [1:0]              reading_status,
	output logic [15:0]             range_mm,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [15:0]        cfg_data
);

	localparam int PW = $clog2(MAX_PINGS + 2);

	urs_pkg::top_state_t state_q, state_d;
	urs_pkg::cfg_t       cfg_q;
	urs_pkg::step_res_t  step_res, hold_q;

	logic [urs_pkg::SUM_W-1:0] avg_sum;
	logic [PW-1:0]             avg_n;
	logic                      avg_done;
	logic [15:0]               avg_value;

	logic        accept, avg_start, load_direct;
	logic        result_valid_q, trigger_q, power_q;
	logic [1:0]  status_q;
	logic [15:0] range_q, last_range_q;

	urs_step #(
		.MAX_PINGS(MAX_PINGS),
		.PW(PW)
	) u_step (
		.clk(clk),
		.arst_n(arst_n),
		.apply(accept),
		.cfg(cfg_q),
		.func(func),
		.echo_level(echo_level),
		.edge_time_us(edge_time_us),
		.ping_count(ping_count),
		.res(step_res),
		.avg_sum(avg_sum),
		.avg_n(avg_n)
	);

	urs_avg #(
		.MAX_PINGS(MAX_PINGS),
		.PW(PW)
	) u_avg (
		.clk(clk),
		.arst_n(arst_n),
		.start(avg_start),
		.sum(avg_sum),
		.n(avg_n),
		.temperature_c(cfg_q.temperature_c),
		.done(avg_done),
		.value(avg_value)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			urs_pkg::T_IDLE: if (avg_start) state_d = urs_pkg::T_AVG;
			urs_pkg::T_AVG:  if (avg_done) state_d = urs_pkg::T_IDLE;
			default:         state_d = urs_pkg::T_IDLE;
		endcase
	end

	always_comb begin
		item_ready  = (state_q == urs_pkg::T_IDLE) && (!result_valid_q || result_ready);
		accept      = item_valid && item_ready;
		avg_start   = accept && step_res.need_avg;
		load_direct = accept && !step_res.need_avg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= urs_pkg::T_IDLE;
			result_valid_q <= 1'b0;
			last_range_q   <= urs_pkg::RANGE_RST;
			cfg_q.temperature_c         <= 8'sd20;
			cfg_q.power_control_present <= 1'b1;
			cfg_q.power_up_ms           <= 16'd100;
		end else begin
			state_q <= state_d;
			if (load_direct || avg_done)
				result_valid_q <= 1'b1;
			else if (result_ready)
				result_valid_q <= 1'b0;
			if (avg_done)
				last_range_q <= avg_value;
			if (cfg_we) begin
				unique case (cfg_index)
					urs_pkg::CFG_TEMP:     cfg_q.temperature_c <= signed'(cfg_data[7:0]);
					urs_pkg::CFG_PWR_CTRL: cfg_q.power_control_present <= cfg_data[0];
					urs_pkg::CFG_PWR_UP:   cfg_q.power_up_ms <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (avg_start)
			hold_q <= step_res;
		if (load_direct) begin
			trigger_q <= step_res.trigger_pulse;
			power_q   <= step_res.power_enable;
			status_q  <= step_res.reading_status;
			range_q   <= last_range_q;
		end else if (avg_done) begin
			trigger_q <= hold_q.trigger_pulse;
			power_q   <= hold_q.power_enable;
			status_q  <= hold_q.reading_status;
			range_q   <= avg_value;
		end
	end

	assign result_valid   = result_valid_q;
	assign trigger_pulse  = trigger_q;
	assign power_enable   = power_q;
	assign reading_status = status_q;
	assign range_mm       = range_q;

	a_done_in_avg: assert property (@(posedge clk) disable iff (!arst_n)
		avg_done |-> state_q == urs_pkg::T_AVG) else $error("average done outside averaging");
	a_no_result_avg: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == urs_pkg::T_AVG |-> !result_valid_q) else $error("result pending while averaging");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !result_valid_q || result_ready) else $error("request taken over held result");

endmodule
`default_nettype wire

// ----- src/urs_step.sv -----
`default_nettype none
module urs_step #(
	parameter int MAX_PINGS = 64,
	parameter int PW = 7
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      apply,
	input  wire urs_pkg::cfg_t             cfg,
	input  wire logic [1:0]                func,
	input  wire logic                      echo_level,
	input  wire logic [31:0]               edge_time_us,
	input  wire logic [6:0]                ping_count,
	output urs_pkg::step_res_t             res,
	output logic [urs_pkg::SUM_W-1:0]      avg_sum,
	output logic [PW-1:0]                  avg_n
);

	localparam int CW = (PW > 7) ? PW : 7;

	logic power_on_q, powering_up_q, power_ready_q, ping_pending_q;
	logic awaiting_q, timing_q, pulse_ready_q, guard_q;
	logic [31:0] pulse_start_q;
	logic [urs_pkg::LEN_W-1:0] pulse_len_q;
	logic [15:0] power_wait_q;
	logic [7:0] echo_wait_q, guard_wait_q;
	logic [PW-1:0] sent_q, wanted_q;
	logic [urs_pkg::SUM_W-1:0] sum_q;

	logic power_on_d, powering_up_d, power_ready_d, ping_pending_d;
	logic awaiting_d, timing_d, pulse_ready_d, guard_d;
	logic [31:0] pulse_start_d;
	logic [urs_pkg::LEN_W-1:0] pulse_len_d;
	logic [15:0] power_wait_d;
	logic [7:0] echo_wait_d, guard_wait_d;
	logic [PW-1:0] sent_d, wanted_d;
	logic [urs_pkg::SUM_W-1:0] sum_d;

	logic stop_c;
	logic [CW-1:0] count_c;
	logic [31:0] diff_c;
	logic [urs_pkg::SUM_W:0] sum_ext_c;

	always_comb begin
		power_on_d     = power_on_q;
		powering_up_d  = powering_up_q;
		power_ready_d  = power_ready_q;
		ping_pending_d = ping_pending_q;
		awaiting_d     = awaiting_q;
		timing_d       = timing_q;
		pulse_ready_d  = pulse_ready_q;
		guard_d        = guard_q;
		pulse_start_d  = pulse_start_q;
		pulse_len_d    = pulse_len_q;
		power_wait_d   = power_wait_q;
		echo_wait_d    = echo_wait_q;
		guard_wait_d   = guard_wait_q;
		sent_d         = sent_q;
		wanted_d       = wanted_q;
		sum_d          = sum_q;
		res.trigger_pulse  = 1'b0;
		res.reading_status = urs_pkg::ST_NONE;
		res.need_avg       = 1'b0;
		avg_sum = sum_q;
		stop_c  = 1'b0;
		count_c = CW'(ping_count);
		diff_c  = edge_time_us - pulse_start_q;
		sum_ext_c = {1'b0, sum_q} + (urs_pkg::SUM_W+1)'(pulse_len_q);

		case (func)
			urs_pkg::FN_TICK: begin
				if (awaiting_q && echo_wait_q != 8'hFF)
					echo_wait_d = echo_wait_q + 8'd1;
				if (guard_q && guard_wait_q != 8'hFF)
					guard_wait_d = guard_wait_q + 8'd1;
				if (powering_up_q) begin
					if (power_wait_q != 16'hFFFF)
						power_wait_d = power_wait_q + 16'd1;
					if (power_wait_d < cfg.power_up_ms) begin
						stop_c = 1'b1;
					end else begin
						powering_up_d = 1'b0;
						power_ready_d = 1'b1;
						if (ping_pending_q) begin
							ping_pending_d    = 1'b0;
							sent_d            = PW'(1);
							timing_d          = 1'b0;
							awaiting_d        = 1'b1;
							echo_wait_d       = 8'd0;
							res.trigger_pulse = 1'b1;
							stop_c            = 1'b1;
						end
					end
				end
				if (!stop_c && awaiting_q && echo_wait_d > urs_pkg::TIMEOUT_MS) begin
					awaiting_d         = 1'b0;
					res.reading_status = urs_pkg::ST_TIMEOUT;
					stop_c             = 1'b1;
				end
				if (!stop_c) begin
					if (pulse_ready_q) begin
						if (sent_q == PW'(1)) begin
							wanted_d = wanted_q + PW'(1);
						end else begin
							sum_d = sum_ext_c[urs_pkg::SUM_W] ? urs_pkg::SUM_MAX
								: sum_ext_c[urs_pkg::SUM_W-1:0];
						end
						pulse_ready_d = 1'b0;
						if (sent_q < wanted_d) begin
							guard_wait_d = 8'd0;
							guard_d      = 1'b1;
						end else begin
							if (cfg.power_control_present) begin
								power_on_d    = 1'b0;
								powering_up_d = 1'b0;
								power_ready_d = 1'b0;
							end
							avg_sum            = sum_d;
							sum_d              = '0;
							res.need_avg       = 1'b1;
							res.reading_status = urs_pkg::ST_READING;
						end
					end else if (guard_q && guard_wait_d >= urs_pkg::GUARD_MS) begin
						timing_d          = 1'b0;
						awaiting_d        = 1'b1;
						echo_wait_d       = 8'd0;
						res.trigger_pulse = 1'b1;
						sent_d            = sent_q + PW'(1);
						guard_d           = 1'b0;
					end
				end
			end
			urs_pkg::FN_EDGE: begin
				if (awaiting_q) begin
					if (echo_level) begin
						pulse_start_d = edge_time_us;
						awaiting_d    = 1'b0;
						timing_d      = 1'b1;
					end
				end else if (timing_q) begin
					if (!echo_level) begin
						pulse_len_d = (diff_c > 32'(urs_pkg::LEN_MAX)) ? urs_pkg::LEN_MAX
							: diff_c[urs_pkg::LEN_W-1:0];
						timing_d      = 1'b0;
						pulse_ready_d = 1'b1;
					end
				end
			end
			urs_pkg::FN_PING: begin
				if (count_c == '0)
					count_c = CW'(1);
				if (count_c > CW'(MAX_PINGS))
					count_c = CW'(MAX_PINGS);
				sum_d         = '0;
				timing_d      = 1'b0;
				awaiting_d    = 1'b0;
				pulse_ready_d = 1'b0;
				guard_d       = 1'b0;
				wanted_d      = count_c[PW-1:0];
				if (cfg.power_control_present && !power_ready_q) begin
					if (!power_on_q) begin
						power_on_d    = 1'b1;
						powering_up_d = 1'b1;
						power_wait_d  = 16'd0;
					end
					ping_pending_d = 1'b1;
				end else begin
					awaiting_d        = 1'b1;
					echo_wait_d       = 8'd0;
					res.trigger_pulse = 1'b1;
					sent_d            = PW'(1);
				end
			end
			default: begin
			end
		endcase
		res.power_enable = !cfg.power_control_present || power_on_d;
		avg_n = (sent_q > PW'(1)) ? (sent_q - PW'(1)) : PW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_on_q     <= 1'b0;
			powering_up_q  <= 1'b0;
			power_ready_q  <= 1'b0;
			ping_pending_q <= 1'b0;
			awaiting_q     <= 1'b0;
			timing_q       <= 1'b0;
			pulse_ready_q  <= 1'b0;
			guard_q        <= 1'b0;
			pulse_start_q  <= '0;
			pulse_len_q    <= '0;
			power_wait_q   <= '0;
			echo_wait_q    <= '0;
			guard_wait_q   <= '0;
			sent_q         <= '0;
			wanted_q       <= '0;
			sum_q          <= '0;
		end else if (apply) begin
			power_on_q     <= power_on_d;
			powering_up_q  <= powering_up_d;
			power_ready_q  <= power_ready_d;
			ping_pending_q <= ping_pending_d;
			awaiting_q     <= awaiting_d;
			timing_q       <= timing_d;
			pulse_ready_q  <= pulse_ready_d;
			guard_q        <= guard_d;
			pulse_start_q  <= pulse_start_d;
			pulse_len_q    <= pulse_len_d;
			power_wait_q   <= power_wait_d;
			echo_wait_q    <= echo_wait_d;
			guard_wait_q   <= guard_wait_d;
			sent_q         <= sent_d;
			wanted_q       <= wanted_d;
			sum_q          <= sum_d;
		end
	end

endmodule
`default_nettype wire

// ----- src/urs_avg.sv -----
`default_nettype none
module urs_avg #(
	parameter int MAX_PINGS = 64,
	parameter int PW = 7
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [urs_pkg::SUM_W-1:0]    sum,
	input  wire logic [PW-1:0]                n,
	input  wire logic signed [7:0]            temperature_c,
	output logic                              done,
	output logic [15:0]                       value
);

	localparam int DW = $clog2(MAX_PINGS * urs_pkg::DIV_SCALE + 1);
	localparam int RW = (DW + 1 > urs_pkg::HI_W) ? DW + 1 : urs_pkg::HI_W;
	localparam int NW = $clog2(urs_pkg::QBITS);

	urs_pkg::avg_state_t state_q, state_d;

	logic [urs_pkg::SUM_W-1:0]  sum_q;
	logic [urs_pkg::SPD_W-1:0]  speed_q;
	logic [DW-1:0]              div_q;
	logic [urs_pkg::PROD_W-1:0] prod_q;
	logic [urs_pkg::QBITS-1:0]  low_q;
	logic [RW-1:0]              rem_q;
	logic [urs_pkg::QBITS-1:0]  quo_q;
	logic [NW-1:0]              cnt_q;
	logic                       sat_q;

	logic [RW-1:0] cand_c;
	logic [RW:0]   diff_c;
	logic          ge_c;
	logic [19:0]   speed_c;

	// one compare/subtract unit serves the overflow check and every quotient bit
	assign cand_c = (state_q == urs_pkg::A_PRE) ? RW'(prod_q[urs_pkg::PROD_W-1:urs_pkg::QBITS])
		: {rem_q[RW-2:0], low_q[urs_pkg::QBITS-1]};
	assign diff_c = {1'b0, cand_c} - {1'b0, RW'(div_q)};
	assign ge_c = !diff_c[RW];
	assign speed_c = 20'(urs_pkg::SPEED_BASE) + 20'(urs_pkg::SPEED_SLOPE * int'(temperature_c));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			urs_pkg::A_IDLE: if (start) state_d = urs_pkg::A_MUL;
			urs_pkg::A_MUL:  state_d = urs_pkg::A_PRE;
			urs_pkg::A_PRE:  state_d = ge_c ? urs_pkg::A_DONE : urs_pkg::A_DIV;
			urs_pkg::A_DIV:  if (cnt_q == '0) state_d = urs_pkg::A_DONE;
			urs_pkg::A_DONE: state_d = urs_pkg::A_IDLE;
			default:         state_d = urs_pkg::A_IDLE;
		endcase
	end

	always_comb begin
		done  = (state_q == urs_pkg::A_DONE);
		value = (sat_q || quo_q[urs_pkg::QBITS-1]) ? urs_pkg::RANGE_MAX : quo_q[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= urs_pkg::A_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			urs_pkg::A_IDLE: begin
				sum_q   <= sum;
				speed_q <= speed_c[urs_pkg::SPD_W-1:0];
				div_q   <= DW'(n * urs_pkg::DIV_SCALE);
			end
			urs_pkg::A_MUL: begin
				prod_q <= urs_pkg::PROD_W'(sum_q) * urs_pkg::PROD_W'(speed_q);
			end
			urs_pkg::A_PRE: begin
				sat_q <= ge_c;
				rem_q <= cand_c;
				low_q <= prod_q[urs_pkg::QBITS-1:0];
				quo_q <= '0;
				cnt_q <= NW'(urs_pkg::QBITS - 1);
			end
			urs_pkg::A_DIV: begin
				rem_q <= ge_c ? diff_c[RW-1:0] : cand_c;
				low_q <= {low_q[urs_pkg::QBITS-2:0], 1'b0};
				quo_q <= {quo_q[urs_pkg::QBITS-2:0], ge_c};
				cnt_q <= cnt_q - NW'(1);
			end
			default: begin
			end
		endcase
	end

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("average done held");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == urs_pkg::A_DIV |-> cnt_q <= NW'(urs_pkg::QBITS - 1))
		else $error("quotient bit count out of range");
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == urs_pkg::A_DIV |-> rem_q < RW'(div_q))
		else $error("partial remainder not below divisor");

endmodule
`default_nettype wire

// ----- tb/tb_ultrasonic_range_sequencer.sv -----
`default_nettype none
module tb_ultrasonic_range_sequencer;

	localparam int PING_LIMIT = 64;
	localparam logic [1:0] FN_NONE = 2'd3;

	typedef struct packed {
		logic             fired;
		logic             powered;
		urs_pkg::status_t status;
		logic [15:0]      dist_mm;
	} ranger_out_t;

	logic clk;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	logic [1:0] func = urs_pkg::FN_TICK;
	logic echo_level = 1'b0;
	logic [31:0] edge_time_us = '0;
	logic [6:0] ping_count = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic trigger_pulse;
	logic power_enable;
	logic [1:0] reading_status;
	logic [15:0] range_mm;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = urs_pkg::CFG_TEMP;
	logic [15:0] cfg_data = '0;

	ultrasonic_range_sequencer #(
		.MAX_PINGS(PING_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.func(func),
		.echo_level(echo_level),
		.edge_time_us(edge_time_us),
		.ping_count(ping_count),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.trigger_pulse(trigger_pulse),
		.power_enable(power_enable),
		.reading_status(reading_status),
		.range_mm(range_mm),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state
	logic signed [7:0] air_temp;
	logic pwr_ctrl;
	logic [15:0] pwr_up_ms;
	logic pwr_on, pwr_rising, pwr_ok, ping_waiting;
	logic echo_armed, echo_high, echo_done, guard_on, trig;
	logic [31:0] rise_us;
	logic [17:0] echo_len;
	logic [15:0] pwr_cnt;
	logic [7:0] echo_cnt, guard_cnt;
	logic [6:0] shots, shots_needed;
	logic [23:0] flight_sum;
	logic [15:0] range_out;

	ranger_out_t pending_readouts[$];
	int error_count = 0;
	int items_sent = 0;
	int readings = 0;
	int timeouts = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;
	urs_pkg::status_t last_status = urs_pkg::ST_NONE;
	logic [31:0] now_us;

	function automatic void reset_model();
		air_temp = 8'sd20;
		pwr_ctrl = 1'b1;
		pwr_up_ms = 16'd100;
		{pwr_on, pwr_rising, pwr_ok, ping_waiting} = '0;
		{echo_armed, echo_high, echo_done, guard_on, trig} = '0;
		rise_us = '0;
		echo_len = '0;
		pwr_cnt = '0;
		echo_cnt = '0;
		guard_cnt = '0;
		shots = '0;
		shots_needed = '0;
		flight_sum = '0;
		range_out = urs_pkg::RANGE_RST;
	endfunction

	function automatic void fire_trigger();
		echo_high = 1'b0;
		echo_armed = 1'b1;
		echo_cnt = '0;
		trig = 1'b1;
	endfunction

	function automatic void sensor_off();
		if (pwr_ctrl) begin
			pwr_on = 1'b0;
			pwr_rising = 1'b0;
			pwr_ok = 1'b0;
		end
	endfunction

	function automatic logic [15:0] mean_range();
		logic [6:0] n;
		int spd;
		logic [63:0] q;
		n = (shots > 7'd1) ? shots - 7'd1 : 7'd1;
		spd = urs_pkg::SPEED_BASE + urs_pkg::SPEED_SLOPE * int'(air_temp);
		q = (64'(flight_sum) * 64'(spd)) / (64'(n) * 64'(urs_pkg::DIV_SCALE));
		return (q > 64'd65535) ? urs_pkg::RANGE_MAX : q[15:0];
	endfunction

	function automatic urs_pkg::status_t tick_update();
		logic [24:0] acc;
		if (echo_armed && echo_cnt < 8'd255) echo_cnt++;
		if (guard_on && guard_cnt < 8'd255) guard_cnt++;
		if (pwr_rising) begin
			if (pwr_cnt < 16'hFFFF) pwr_cnt++;
			if (pwr_cnt < pwr_up_ms) return urs_pkg::ST_NONE;
			pwr_rising = 1'b0;
			pwr_ok = 1'b1;
			if (ping_waiting) begin
				ping_waiting = 1'b0;
				shots = 7'd1;
				fire_trigger();
				return urs_pkg::ST_NONE;
			end
		end
		if (echo_armed && echo_cnt > urs_pkg::TIMEOUT_MS) begin
			echo_armed = 1'b0;
			return urs_pkg::ST_TIMEOUT;
		end
		if (echo_done) begin
			if (shots == 7'd1) begin
				shots_needed++;
			end else begin
				acc = 25'(flight_sum) + 25'(echo_len);
				flight_sum = (acc > 25'(urs_pkg::SUM_MAX)) ? urs_pkg::SUM_MAX : acc[23:0];
			end
			echo_done = 1'b0;
			if (shots < shots_needed) begin
				guard_cnt = '0;
				guard_on = 1'b1;
			end else begin
				sensor_off();
				range_out = mean_range();
				flight_sum = '0;
				return urs_pkg::ST_READING;
			end
		end else if (guard_on && guard_cnt >= urs_pkg::GUARD_MS) begin
			fire_trigger();
			shots++;
			guard_on = 1'b0;
		end
		return urs_pkg::ST_NONE;
	endfunction

	function automatic void echo_update(input logic lvl, input logic [31:0] t);
		logic [31:0] d;
		if (echo_armed) begin
			if (lvl) begin
				rise_us = t;
				echo_armed = 1'b0;
				echo_high = 1'b1;
			end
		end else if (echo_high && !lvl) begin
			d = t - rise_us;
			echo_len = (d > 32'(urs_pkg::LEN_MAX)) ? urs_pkg::LEN_MAX : d[17:0];
			echo_high = 1'b0;
			echo_done = 1'b1;
		end
	endfunction

	function automatic void ping_update(input logic [6:0] cnt);
		logic [6:0] c;
		c = (cnt == 7'd0) ? 7'd1 : cnt;
		if (c > 7'(PING_LIMIT)) c = 7'(PING_LIMIT);
		flight_sum = '0;
		echo_high = 1'b0;
		echo_armed = 1'b0;
		echo_done = 1'b0;
		guard_on = 1'b0;
		shots_needed = c;
		if (pwr_ctrl && !pwr_ok) begin
			if (!pwr_on) begin
				pwr_on = 1'b1;
				pwr_rising = 1'b1;
				pwr_cnt = '0;
			end
			ping_waiting = 1'b1;
		end else begin
			fire_trigger();
			shots = 7'd1;
		end
	endfunction

	function automatic ranger_out_t sequencer_step(input logic [1:0] fn, input logic lvl,
			input logic [31:0] t, input logic [6:0] cnt);
		ranger_out_t r;
		urs_pkg::status_t st;
		st = urs_pkg::ST_NONE;
		trig = 1'b0;
		case (fn)
			urs_pkg::FN_TICK: st = tick_update();
			urs_pkg::FN_EDGE: echo_update(lvl, t);
			urs_pkg::FN_PING: ping_update(cnt);
			default: ;
		endcase
		r.fired = trig;
		r.powered = !pwr_ctrl || pwr_on;
		r.status = st;
		r.dist_mm = range_out;
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("ultrasonic_range_sequencer test failed");
		$finish;
	end

	// receiver: long hold-offs on request, otherwise random stalls
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	task automatic check_field(input string what, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin : check_results
		ranger_out_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_readouts.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result, expected none, got trig=%0b pwr=%0b st=%0d mm=%0d",
					$time, trigger_pulse, power_enable, reading_status, range_mm);
			end else begin
				want = pending_readouts.pop_front();
				check_field("trigger_pulse", 16'(want.fired), 16'(trigger_pulse));
				check_field("power_enable", 16'(want.powered), 16'(power_enable));
				check_field("reading_status", 16'(want.status), 16'(reading_status));
				check_field("range_mm", want.dist_mm, range_mm);
			end
		end
	end

	task automatic send_item(input logic [1:0] fn, input logic lvl, input logic [31:0] t,
			input logic [6:0] cnt);
		ranger_out_t r;
		item_valid <= 1'b1;
		func <= fn;
		echo_level <= lvl;
		edge_time_us <= t;
		ping_count <= cnt;
		do @(posedge clk); while (!item_ready);
		r = sequencer_step(fn, lvl, t, cnt);
		pending_readouts.push_back(r);
		items_sent++;
		last_status = r.status;
		if (r.status == urs_pkg::ST_READING) readings++;
		if (r.status == urs_pkg::ST_TIMEOUT) timeouts++;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic send_tick();
		now_us += 32'd1000 + 32'($urandom_range(0, 3));
		send_item(urs_pkg::FN_TICK, 1'($urandom), $urandom, 7'($urandom));
	endtask

	task automatic send_echo(input logic lvl, input logic [31:0] t);
		send_item(urs_pkg::FN_EDGE, lvl, t, 7'($urandom));
	endtask

	task automatic send_ping(input logic [6:0] cnt);
		send_item(urs_pkg::FN_PING, 1'($urandom), $urandom, cnt);
	endtask

	function automatic logic [31:0] pick_len(input bit long_pulses);
		int r;
		r = $urandom_range(0, 19);
		if (long_pulses || r < 2) return 32'(urs_pkg::LEN_MAX) - 3 + $urandom_range(0, 4000);
		if (r == 2) return $urandom;
		return $urandom_range(0, 30000);
	endfunction

	// steps the sensor side through trigger, echo and guard until a reading, a timeout or the item cap
	task automatic drive_echoes(input bit force_timeout, input bit long_pulses, input int cap);
		int k;
		k = 0;
		last_status = urs_pkg::ST_NONE;
		while (k < cap && last_status == urs_pkg::ST_NONE) begin
			if (echo_armed && !force_timeout && $urandom_range(0, 2) == 0) begin
				if ($urandom_range(0, 15) == 0) send_echo(1'b0, now_us);
				else send_echo(1'b1, now_us + $urandom_range(0, 999));
			end else if (echo_high && $urandom_range(0, 3) != 0) begin
				if ($urandom_range(0, 9) == 0) begin
					send_echo(1'b1, now_us);
				end else begin
					now_us = rise_us + pick_len(long_pulses);
					send_echo(1'b0, now_us);
				end
			end else begin
				send_tick();
			end
			k++;
		end
	endtask

	task automatic run_ranging(input logic [6:0] cnt, input bit force_timeout,
			input bit long_pulses, input int cap);
		send_ping(cnt);
		drive_echoes(force_timeout, long_pulses, cap);
	endtask

	task automatic wait_idle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_readouts.size() != 0) @(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			urs_pkg::CFG_TEMP: air_temp = val[7:0];
			urs_pkg::CFG_PWR_CTRL: pwr_ctrl = val[0];
			urs_pkg::CFG_PWR_UP: pwr_up_ms = val;
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] tc, input logic pc, input logic [15:0] pu);
		wait_idle();
		write_reg(urs_pkg::CFG_TEMP, {{8{tc[7]}}, tc});
		write_reg(urs_pkg::CFG_PWR_CTRL, 16'(pc));
		write_reg(urs_pkg::CFG_PWR_UP, pu);
	endtask

	// stray edges, unused selector and count limits before any power-up completes
	task automatic test_idle_items();
		send_tick();
		send_item(FN_NONE, 1'b1, 32'hFFFF_FFFF, 7'h7F);
		send_echo(1'b1, 32'h0000_0000);
		send_echo(1'b0, 32'hFFFF_FFFF);
		send_ping(7'd0);
		send_tick();
		send_echo(1'b1, now_us);
		send_ping(7'd127);
		send_ping(7'd65);
		send_item(FN_NONE, 1'b0, 32'h0, 7'h0);
		send_tick();
		wait_idle();
	endtask

	task automatic test_default_reading();
		run_ranging(7'd1, 1'b0, 1'b0, 3000);
		wait_idle();
	endtask

	task automatic test_always_powered();
		set_config(8'hD8, 1'b0, 16'hFFFF);
		run_ranging(7'd2, 1'b0, 1'b0, 3000);
		wait_idle();
	endtask

	task automatic test_long_echoes();
		set_config(8'sd85, 1'b1, 16'd0);
		run_ranging(7'd2, 1'b0, 1'b1, 3000);
		wait_idle();
	endtask

	task automatic test_restart();
		int k;
		set_config(8'h80, 1'b1, 16'd1);
		send_ping(7'd64);
		k = 0;
		while (!echo_high && k < 1000) begin
			drive_echoes(1'b0, 1'b0, 1);
			k++;
		end
		send_ping(7'd2);
		k = 0;
		while (!guard_on && k < 1000) begin
			drive_echoes(1'b0, 1'b0, 1);
			k++;
		end
		drive_echoes(1'b0, 1'b0, 20);
		run_ranging(7'd1, 1'b0, 1'b0, 3000);
		wait_idle();
	endtask

	task automatic test_timeout();
		set_config(8'sd127, 1'b1, 16'd3);
		run_ranging(7'd1, 1'b1, 1'b0, 3000);
		run_ranging(7'd1, 1'b0, 1'b0, 3000);
		wait_idle();
	endtask

	task automatic test_backpressure();
		hold_left = 300;
		repeat (40) send_tick();
		send_ping(7'd1);
		repeat (10) send_tick();
		wait_idle();
	endtask

	task automatic test_random_phase(input int s_pct, input int r_pct);
		int start;
		int choice;
		logic [7:0] tc;
		if ($urandom_range(0, 3) == 0) tc = 8'($urandom);
		else tc = 8'($urandom_range(0, 125) - 40);
		set_config(tc, 1'($urandom), 16'($urandom_range(0, 4)));
		send_idle_pct = s_pct;
		recv_stall_pct = r_pct;
		start = items_sent;
		while (items_sent - start < 60) begin
			choice = $urandom_range(0, 99);
			if (choice < 55) begin
				run_ranging(7'($urandom_range(0, 2)), 1'b0, 1'b0, 3000);
			end else if (choice < 70) begin
				run_ranging(7'($urandom_range(0, 3)), 1'b1, 1'b0, 3000);
			end else if (choice < 85) begin
				run_ranging(7'($urandom), 1'b0, 1'b0, $urandom_range(5, 300));
			end else begin
				repeat ($urandom_range(4, 16))
					send_item(2'($urandom), 1'($urandom), $urandom, 7'($urandom));
			end
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		reset_model();
		now_us = $urandom;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_items();
		test_default_reading();
		test_always_powered();
		test_long_echoes();
		test_restart();
		test_timeout();
		test_backpressure();
		test_random_phase(0, 0);
		test_random_phase(69, 0);
		test_random_phase(0, 69);
		test_random_phase(6, 6);
		wait_idle();
		$display("covered %0d requests: %0d averaged readings, %0d ping timeouts,",
			items_sent, readings, timeouts);
		$display("temperature and power settings at their extremes, restarts and stalls");
		if (error_count == 0) begin
			$display("ultrasonic_range_sequencer test passed");
		end else begin
			$display("ultrasonic_range_sequencer test failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
